>>> rtl/sfrx_pkg.sv
// ============================================================================
// sfrx_pkg
// Shared constants, codes and handshake types of the serial frame receiver.
// ============================================================================
package sfrx_pkg;

    localparam int MAX_PAYLOAD_DEF = 30;

    localparam int KIND_W = 2;
    localparam int VALUE_W = 8;
    localparam int PORT_W = 4;
    localparam int LENGTH_W = 5;
    localparam int POSITION_W = 6;

    localparam logic [VALUE_W-1:0] START_BYTE_RST = 8'hAA;
    localparam logic [PORT_W-1:0] SETPOINT_PORT_RST = 4'd3;
    localparam logic [VALUE_W-1:0] ACK_ZERO = 8'h00;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_PORT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic good;
        logic bad;
    } frame_evt_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } emit_stat_t;

endpackage

>>> rtl/sfrx_payload_ram.sv
// ============================================================================
// sfrx_payload_ram
// Payload buffer: one write port, one read port, registered read data.
// ============================================================================
module sfrx_payload_ram #(
    parameter int DEPTH = sfrx_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if ({1'b0, raddr} < (ADDR_W + 1)'(DEPTH))
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sfrx_parser.sv
// ============================================================================
// sfrx_parser
// Frame hunt, header and length capture, payload buffering and running sum.
// ============================================================================
module sfrx_parser #(
    parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    parameter int LEN_W = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            start_byte,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  sfrx_pkg::emit_stat_t  stat,
    output sfrx_pkg::frame_evt_t  evt,
    output logic [7:0]            held_header,
    output logic [LEN_W-1:0]      held_length,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [7:0]            wr_data
);

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       header_reg, header_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] index_reg, index_next;
    logic [7:0]       sum_reg, sum_next;
    logic             take;
    logic [LEN_W-1:0] index_inc;

    assign in_ready = !stat.busy && ((phase_reg != PH_CHECK) || stat.out_free);
    assign take = in_valid && in_ready;
    assign index_inc = index_reg + LEN_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        header_next = header_reg;
        length_next = length_reg;
        index_next = index_reg;
        sum_next = sum_reg;
        evt = '0;
        wr_en = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte != start_byte)
                    begin
                        header_next = rx_byte;
                        sum_next = rx_byte;
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        length_next = rx_byte[LEN_W-1:0];
                        index_next = '0;
                        phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    wr_en = 1'b1;
                    index_next = index_inc;
                    sum_next = sum_reg + rx_byte;
                    if (index_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    evt.good = (rx_byte == sum_reg);
                    evt.bad = (rx_byte != sum_reg);
                    phase_next = PH_WAIT;
                end
                default:
                begin
                    phase_next = (rx_byte == start_byte) ? PH_HEADER : PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            header_reg <= '0;
            length_reg <= '0;
            index_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            header_reg <= header_next;
            length_reg <= length_next;
            index_reg <= index_next;
            sum_reg <= sum_next;
        end
    end

    assign held_header = header_reg;
    assign held_length = length_reg;
    assign wr_addr = index_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

endmodule

>>> rtl/sfrx_emitter.sv
// ============================================================================
// sfrx_emitter
// Result sequencer: accept, payload readback and acknowledge bytes, or error.
// ============================================================================
module sfrx_emitter #(
    parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    parameter int LEN_W = $clog2(MAX_PAYLOAD + 1),
    parameter int POS_W = $clog2(MAX_PAYLOAD + 7)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfrx_pkg::frame_evt_t                evt,
    input  logic [7:0]                          held_header,
    input  logic [LEN_W-1:0]                    held_length,
    input  logic [7:0]                          start_byte,
    input  logic [sfrx_pkg::PORT_W-1:0]         setpoint_port,
    output logic [ADDR_W-1:0]                   rd_addr,
    input  logic [7:0]                          rd_data,
    output sfrx_pkg::emit_stat_t                stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfrx_pkg::KIND_W-1:0]         kind,
    output logic [sfrx_pkg::VALUE_W-1:0]        value,
    output logic [7:0]                          frame_header,
    output logic [sfrx_pkg::PORT_W-1:0]         port,
    output logic                                to_setpoint,
    output logic [sfrx_pkg::LENGTH_W-1:0]       payload_length,
    output logic [sfrx_pkg::POSITION_W-1:0]     position,
    output logic                                last
);

    logic                          busy_reg, busy_next;
    logic                          fresh_reg, fresh_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          valid_reg, valid_next;
    logic [sfrx_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [7:0]                    value_reg, value_next;
    logic [7:0]                    header_reg, header_next;
    logic                          setpt_reg, setpt_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [POS_W-1:0]              opos_reg, opos_next;
    logic                          last_reg, last_next;

    logic                          out_free;
    logic                          load;
    logic [POS_W-1:0]              len_ext;
    logic [sfrx_pkg::KIND_W-1:0]   seq_kind;
    logic [7:0]                    seq_value;
    logic                          seq_last;
    logic                          hdr_match;

    assign out_free = !valid_reg || out_ready;
    assign load = busy_reg && fresh_reg && out_free;
    assign len_ext = POS_W'(held_length);
    assign hdr_match = (held_header[7:4] == setpoint_port);
    assign rd_addr = ADDR_W'(pos_reg - POS_W'(1));
    assign stat.busy = busy_reg;
    assign stat.out_free = out_free;

    always_comb
    begin
        seq_last = 1'b0;
        priority if (pos_reg == '0)
        begin
            seq_kind = sfrx_pkg::KIND_ACCEPT;
            seq_value = 8'd0;
        end
        else if (pos_reg <= len_ext)
        begin
            seq_kind = sfrx_pkg::KIND_PAYLOAD;
            seq_value = rd_data;
        end
        else if (pos_reg == len_ext + POS_W'(1) || pos_reg == len_ext + POS_W'(2))
        begin
            seq_kind = sfrx_pkg::KIND_ACK;
            seq_value = start_byte;
        end
        else if (pos_reg == len_ext + POS_W'(4))
        begin
            seq_kind = sfrx_pkg::KIND_ACK;
            seq_value = sfrx_pkg::ACK_ZERO;
        end
        else
        begin
            seq_kind = sfrx_pkg::KIND_ACK;
            seq_value = held_header;
            seq_last = (pos_reg == len_ext + POS_W'(5));
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next = pos_reg;
        fresh_next = busy_reg && !load;
        valid_next = valid_reg && !out_ready;
        kind_next = kind_reg;
        value_next = value_reg;
        header_next = header_reg;
        setpt_next = setpt_reg;
        len_next = len_reg;
        opos_next = opos_reg;
        last_next = last_reg;
        if (evt.good)
        begin
            busy_next = 1'b1;
            pos_next = '0;
            fresh_next = 1'b0;
        end
        else if (evt.bad)
        begin
            valid_next = 1'b1;
            kind_next = sfrx_pkg::KIND_ERROR;
            value_next = 8'd0;
            header_next = held_header;
            setpt_next = hdr_match;
            len_next = held_length;
            opos_next = '0;
            last_next = 1'b1;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            kind_next = seq_kind;
            value_next = seq_value;
            header_next = held_header;
            setpt_next = hdr_match;
            len_next = held_length;
            opos_next = pos_reg;
            last_next = seq_last;
            pos_next = pos_reg + POS_W'(1);
            busy_next = !seq_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fresh_reg <= 1'b0;
            pos_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fresh_reg <= fresh_next;
            pos_reg <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        value_reg <= value_next;
        header_reg <= header_next;
        setpt_reg <= setpt_next;
        len_reg <= len_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign kind = kind_reg;
    assign value = value_reg;
    assign frame_header = header_reg;
    assign port = header_reg[7:4];
    assign to_setpoint = setpt_reg;
    assign payload_length = sfrx_pkg::LENGTH_W'(len_reg);
    assign position = sfrx_pkg::POSITION_W'(opos_reg);
    assign last = last_reg;

endmodule

>>> rtl/serial_frame_receiver_with_ack.sv
// ============================================================================
// serial_frame_receiver_with_ack
// Length-prefixed serial frame receiver with 8-bit sum check and acknowledge.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received byte per
//   request. Output channel (out_valid/out_ready) returns result items held
//   in an output register. Configuration writes (cfg_we/cfg_index/cfg_data)
//   take effect at the next edge; write them only while the block is idle.
//   Header, length and payload bytes are taken one per cycle while no
//   run is in progress; payload bytes are written into the payload RAM
//   as they arrive. A checksum byte with a bad sum yields one error item
//   in the next cycle. A good sum yields length+6 items; after each item
//   the sequencer waits for the registered RAM read data before loading
//   the next, and it holds at output stalls. No input is taken during that
//   run. A stalled receiver holds the output register; input is still
//   taken unless a checksum byte arrives or a run is in progress.
//   Reset returns to hunting for the start byte, restores the register
//   defaults and empties the output register. The RAM is not cleared.
// ============================================================================
module serial_frame_receiver_with_ack #(
    parameter int MAX_PAYLOAD = sfrx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sfrx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfrx_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfrx_pkg::KIND_W-1:0]         kind,
    output logic [sfrx_pkg::VALUE_W-1:0]        value,
    output logic [7:0]                          frame_header,
    output logic [sfrx_pkg::PORT_W-1:0]         port,
    output logic                                to_setpoint,
    output logic [sfrx_pkg::LENGTH_W-1:0]       payload_length,
    output logic [sfrx_pkg::POSITION_W-1:0]     position,
    output logic                                last
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W = $clog2(MAX_PAYLOAD + 7);

    logic [7:0]                   start_byte_reg;
    logic [sfrx_pkg::PORT_W-1:0]  setpoint_port_reg;

    sfrx_pkg::frame_evt_t         evt;
    sfrx_pkg::emit_stat_t         stat;
    logic [7:0]                   held_header;
    logic [LEN_W-1:0]             held_length;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [7:0]                   wr_data;
    logic [ADDR_W-1:0]            rd_addr;
    logic [7:0]                   rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= sfrx_pkg::START_BYTE_RST;
            setpoint_port_reg <= sfrx_pkg::SETPOINT_PORT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sfrx_pkg::CFG_START_BYTE)
            begin
                start_byte_reg <= cfg_data[7:0];
            end
            else if (cfg_index == sfrx_pkg::CFG_SETPOINT_PORT)
            begin
                setpoint_port_reg <= cfg_data[sfrx_pkg::PORT_W-1:0];
            end
        end
    end

    sfrx_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W),
        .LEN_W       (LEN_W)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_byte  (start_byte_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .stat        (stat),
        .evt         (evt),
        .held_header (held_header),
        .held_length (held_length),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    sfrx_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sfrx_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W),
        .LEN_W       (LEN_W),
        .POS_W       (POS_W)
    ) u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt            (evt),
        .held_header    (held_header),
        .held_length    (held_length),
        .start_byte     (start_byte_reg),
        .setpoint_port  (setpoint_port_reg),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .value          (value),
        .frame_header   (frame_header),
        .port           (port),
        .to_setpoint    (to_setpoint),
        .payload_length (payload_length),
        .position       (position),
        .last           (last)
    );

endmodule

>>> rtl/sfrx_checker.sv
// ============================================================================
// sfrx_checker
// Port-level checks of the frame receiver, bound to the top level.
// ============================================================================
module sfrx_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sfrx_pkg::KIND_W-1:0]         kind,
    input  logic [sfrx_pkg::VALUE_W-1:0]        value,
    input  logic [7:0]                          frame_header,
    input  logic [sfrx_pkg::PORT_W-1:0]         port,
    input  logic [sfrx_pkg::POSITION_W-1:0]     position,
    input  logic                                last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
            && $stable(position) && $stable(last))
        else $error("result changed while stalled");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sfrx_pkg::KIND_ERROR |-> last && position == '0 && value == '0)
        else $error("error item is not a single closing item");

    a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sfrx_pkg::KIND_ACCEPT |-> position == '0 && !last && value == '0)
        else $error("accept item misplaced");

    a_port_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> port == frame_header[7:4])
        else $error("port does not match header");

endmodule

bind serial_frame_receiver_with_ack sfrx_checker u_sfrx_checker (.*);

>>> tb/sv/sfrx_check_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfrx_check_pkg
// Result tracking for the serial frame receiver testbench: a bit-exact
// deframer that turns each accepted request byte into the expected result
// items, and the ordered check of the items the block returns.
// ============================================================================
package sfrx_check_pkg;

    import sfrx_pkg::*;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_HEADER,
        RX_LENGTH,
        RX_PAYLOAD,
        RX_CHECKSUM
    } rx_phase_e;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [VALUE_W-1:0]    value;
        logic [7:0]            header;
        logic [PORT_W-1:0]     port;
        logic                  to_setpoint;
        logic [LENGTH_W-1:0]   length;
        logic [POSITION_W-1:0] position;
        logic                  last;
    } rx_item_t;

    class deframer_tracker;
        rx_phase_e           phase;
        logic [7:0]          hdr;
        logic [LENGTH_W-1:0] len;
        int                  count;
        logic [7:0]          sum;
        logic [7:0]          payload [MAX_PAYLOAD_DEF];
        logic [7:0]          start_byte;
        logic [PORT_W-1:0]   sp_port;
        rx_item_t            pending_items [$];
        int                  failures;

        function new();
            phase = RX_HUNT;
            hdr = 8'h00;
            len = '0;
            count = 0;
            sum = 8'h00;
            start_byte = START_BYTE_RST;
            sp_port = SETPOINT_PORT_RST;
            failures = 0;
            foreach (payload[i])
                payload[i] = 8'h00;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_START_BYTE)
                start_byte = data;
            else if (idx == CFG_SETPOINT_PORT)
                sp_port = data[PORT_W-1:0];
        endfunction

        function int pending();
            return pending_items.size();
        endfunction

        function void add_item(input logic [KIND_W-1:0] kind, input logic [7:0] value,
                               input int pos, input int total);
            rx_item_t it;
            it.kind = kind;
            it.value = value;
            it.header = hdr;
            it.port = hdr[7:4];
            it.to_setpoint = (hdr[7:4] == sp_port);
            it.length = len;
            it.position = pos[POSITION_W-1:0];
            it.last = (pos == total - 1);
            pending_items.push_back(it);
        endfunction

        function void take_byte(input logic [7:0] b);
            int total;
            case (phase)
                RX_HEADER:
                begin
                    if (b != start_byte)
                    begin
                        hdr = b;
                        sum = b;
                        phase = RX_LENGTH;
                    end
                end
                RX_LENGTH:
                begin
                    sum = sum + b;
                    if (b > MAX_PAYLOAD_DEF)
                        phase = RX_HUNT;
                    else
                    begin
                        len = b[LENGTH_W-1:0];
                        count = 0;
                        phase = (b == 8'h00) ? RX_CHECKSUM : RX_PAYLOAD;
                    end
                end
                RX_PAYLOAD:
                begin
                    payload[count] = b;
                    count++;
                    sum = sum + b;
                    if (count >= len)
                        phase = RX_CHECKSUM;
                end
                RX_CHECKSUM:
                begin
                    if (b == sum)
                    begin
                        total = int'(len) + 6;
                        add_item(KIND_ACCEPT, 8'h00, 0, total);
                        for (int i = 0; i < len; i++)
                            add_item(KIND_PAYLOAD, payload[i], i + 1, total);
                        add_item(KIND_ACK, start_byte, total - 5, total);
                        add_item(KIND_ACK, start_byte, total - 4, total);
                        add_item(KIND_ACK, hdr, total - 3, total);
                        add_item(KIND_ACK, ACK_ZERO, total - 2, total);
                        add_item(KIND_ACK, hdr, total - 1, total);
                    end
                    else
                        add_item(KIND_ERROR, 8'h00, 0, 1);
                    phase = RX_HUNT;
                end
                default:
                    phase = (b == start_byte) ? RX_HEADER : RX_HUNT;
            endcase
        endfunction

        function string describe(input rx_item_t it);
            return $sformatf("kind %0d value %02h header %02h port %0d sp %0b len %0d pos %0d last %0b",
                             it.kind, it.value, it.header, it.port, it.to_setpoint,
                             it.length, it.position, it.last);
        endfunction

        function void match_item(input rx_item_t got);
            rx_item_t want;
            if (pending_items.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result: %s", describe(got));
                return;
            end
            want = pending_items.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.header !== want.header || got.port !== want.port ||
                got.to_setpoint !== want.to_setpoint || got.length !== want.length ||
                got.position !== want.position || got.last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("ERROR: result mismatch");
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function void flush_leftovers();
            rx_item_t want;
            while (pending_items.size() != 0)
            begin
                want = pending_items.pop_front();
                failures++;
                if (failures <= 10)
                    $display("ERROR: missing result: %s", describe(want));
            end
        endfunction
    endclass

endpackage

>>> tb/sv/serial_frame_receiver_with_ack_test.sv
`timescale 1ns / 1ps
// ============================================================================
// serial_frame_receiver_with_ack_test
// Drives received bytes into the frame receiver under random sender bursts
// and receiver stalls, predicts accept, payload, acknowledge and error items,
// and checks every returned item in order across several register settings.
// ============================================================================
module serial_frame_receiver_with_ack_test;

    import sfrx_pkg::*;
    import sfrx_check_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BLOCKS
    } stall_mode_e;

    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT = 100000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_START_BYTE;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [7:0]                  rx_byte = 8'h00;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [KIND_W-1:0]           kind;
    logic [VALUE_W-1:0]          value;
    logic [7:0]                  frame_header;
    logic [PORT_W-1:0]           port;
    logic                        to_setpoint;
    logic [LENGTH_W-1:0]         payload_length;
    logic [POSITION_W-1:0]       position;
    logic                        last;

    deframer_tracker tracker;
    int              burst_left = 0;
    stall_mode_e     ready_mode = READY_ALWAYS;
    int              ready_left = 0;
    int              hold_left = 0;
    logic            hold_level = 1'b0;

    serial_frame_receiver_with_ack u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .value          (value),
        .frame_header   (frame_header),
        .port           (port),
        .to_setpoint    (to_setpoint),
        .payload_length (payload_length),
        .position       (position),
        .last           (last)
    );

    always #6 clk = ~clk;

    initial
    begin
        #7_200_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = stall_mode_e'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS:
                out_ready <= 1'b1;
            READY_COIN:
                out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:
                out_ready <= ($urandom_range(0, 7) == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_level = ~hold_level;
                    hold_left = $urandom_range(1, 24);
                end
                hold_left--;
                out_ready <= hold_level;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_item({kind, value, frame_header, port, to_setpoint,
                                payload_length, position, last});
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_byte(b);
    endtask

    // send starts, header and length; for a valid length, up to keep payload bytes, then the checksum once all are sent
    task automatic send_frame(input int extra_starts, input logic [7:0] hdr,
                              input int len_byte, input bit good, input int keep);
        logic [7:0] sum;
        logic [7:0] b;
        repeat (extra_starts + 1) send_byte(tracker.start_byte);
        send_byte(hdr);
        send_byte(len_byte[7:0]);
        if (len_byte > MAX_PAYLOAD_DEF)
            return;
        sum = hdr + len_byte[7:0];
        for (int i = 0; i < len_byte && i < keep; i++)
        begin
            b = ($urandom_range(0, 3) == 0) ? tracker.start_byte : 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        if (keep < len_byte)
            return;
        send_byte(good ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    task automatic flush_frame();
        logic [7:0] filler;
        filler = (tracker.start_byte == 8'hFF) ? 8'hFE : 8'hFF;
        while (tracker.phase != RX_HUNT)
            send_byte(filler);
    endtask

    task automatic drain_and_settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] start_val, input logic [7:0] port_val);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data <= start_val;
        @(posedge clk);
        tracker.set_register(CFG_START_BYTE, start_val);
        cfg_index <= CFG_SETPOINT_PORT;
        cfg_data <= port_val;
        @(posedge clk);
        tracker.set_register(CFG_SETPOINT_PORT, port_val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_round(input int target);
        int         sent;
        int         pick;
        int         len;
        logic [7:0] hdr;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            do
                hdr = ($urandom_range(0, 2) == 0) ? {tracker.sp_port, 4'($urandom_range(0, 15))}
                                                  : 8'($urandom_range(0, 255));
            while (hdr == tracker.start_byte);
            if (pick < 70)
            begin
                len = $urandom_range(0, 19);
                len = (len < 16) ? $urandom_range(0, 6)
                    : (len < 19) ? $urandom_range(7, MAX_PAYLOAD_DEF - 1) : MAX_PAYLOAD_DEF;
                send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, hdr, len,
                           $urandom_range(0, 4) != 0, len);
                sent += len + 4;
            end
            else if (pick < 80)
            begin
                send_frame(0, hdr, $urandom_range(MAX_PAYLOAD_DEF + 1, 255), 1'b1, 0);
                sent += 3;
            end
            else if (pick < 88)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                len = $urandom_range(2, 12);
                send_frame(0, hdr, len, 1'b1, $urandom_range(0, len - 1));
                sent += 3;
            end
        end
        flush_frame();
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_regs(START_BYTE_RST, {4'h0, SETPOINT_PORT_RST});

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(2, 8'h3F, 0, 1'b1, 0);
        send_frame(0, 8'hFF, MAX_PAYLOAD_DEF + 1, 1'b1, 0);
        send_frame(0, 8'h12, 2, 1'b0, 2);
        send_frame(0, 8'h00, 255, 1'b1, 0);
        send_frame(0, 8'hF0, 1, 1'b1, 1);
        flush_frame();
        drain_and_settle();

        program_regs(8'h00, 8'h00);
        random_round(70);
        drain_and_settle();

        program_regs(8'hFF, 8'hFF);
        random_round(70);
        drain_and_settle();

        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_round(80);
        drain_and_settle();

        program_regs(START_BYTE_RST, {4'hA, SETPOINT_PORT_RST});
        random_round(80);
        drain_and_settle();

        tracker.flush_leftovers();
        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
